@@ src/ptat_pkg.sv @@
// types and codes shared by the page table translation block
`timescale 1ns / 1ps

package ptat_pkg;

	localparam int STATUS_W = 3;
	localparam int FRAME_W  = 3;
	localparam int PHYS_W   = 11;
	localparam int PAGE_W   = 5;
	localparam int VADDR_W  = 16;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_XLATE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MAPPED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NO_FRAME = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FAULT    = 3'd4;

	typedef struct packed {
		logic               op;
		logic [PAGE_W-1:0]  vpage;
		logic [VADDR_W-1:0] vaddr;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FRAME_W-1:0]  frame;
		logic [PHYS_W-1:0]   paddr;
	} rsp_t;

endpackage

@@ src/page_table_alloc_translate_top.sv @@
// page table with frame allocation and address translation, top level
//
//   channel   signals          transfer when
//   request   start, req       start high and busy low
//   result    done, rsp        done high, one cycle, no back pressure
//
// one request per cycle; its result is registered through vld_s1 and then done_q and rsp_q
// the frame map lives in a synchronous memory read at accept
// a write in the same cycle to the page being read is forwarded
// frames are taken in order and never freed, so a fill count stands for the busy map
// reset clears valid bits and the fill count at once; no clearing pass
// busy stays low: the block never stalls, and the receiver cannot stall
`timescale 1ns / 1ps

module page_table_alloc_translate_top
	import ptat_pkg::*;
#(
	parameter int NUM_PAGES    = 16,
	parameter int NUM_FRAMES_P = 8,
	parameter int PAGE_BYTES   = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int PW  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int FW  = (NUM_FRAMES_P > 1) ? $clog2(NUM_FRAMES_P) : 1;
	localparam int FCW = $clog2(NUM_FRAMES_P + 1);
	localparam int OW  = $clog2(PAGE_BYTES);
	localparam int SPW = VADDR_W + 1;

	logic accept;
	logic [SPW-1:0] va_page;
	logic [SPW-1:0] sel_page;
	logic [PW-1:0]  in_idx;
	logic           in_range;

	logic          vld_s1;
	logic          op_s1;
	logic          inr_s1;
	logic [PW-1:0] idx_s1;
	logic [OW-1:0] off_s1;
	logic [FW-1:0] rd_frame_s1;
	logic          fwd_s1;
	logic [FW-1:0] fwd_frame_s1;

	logic [FW-1:0]    frame_mem [NUM_PAGES];
	logic [NUM_PAGES-1:0] entry_valid_q;
	logic [FCW-1:0]   next_frame_q;

	logic          wr_en;
	logic [FW-1:0] wr_frame;
	logic [FW-1:0] cur_frame;
	logic          hit;
	rsp_t          rsp_d;
	logic [FW+OW-1:0] phys_full;

	logic done_q;
	rsp_t rsp_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign va_page  = SPW'(req.vaddr) >> OW;
	assign sel_page = (req.op == OP_XLATE) ? va_page : SPW'(req.vpage);
	assign in_range = sel_page < SPW'(NUM_PAGES);
	assign in_idx   = sel_page[PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1        <= req.op;
			inr_s1       <= in_range;
			idx_s1       <= in_idx;
			off_s1       <= req.vaddr[OW-1:0];
			fwd_s1       <= wr_en && (idx_s1 == in_idx);
			fwd_frame_s1 <= wr_frame;
		end
	end

	// frame map memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			frame_mem[idx_s1] <= wr_frame;
		end
		if (accept) begin
			rd_frame_s1 <= frame_mem[in_idx];
		end
	end

	assign hit       = entry_valid_q[idx_s1];
	assign cur_frame = fwd_s1 ? fwd_frame_s1 : rd_frame_s1;
	assign wr_frame  = next_frame_q[FW-1:0];
	assign phys_full = {cur_frame, off_s1};

	always_comb begin
		wr_en = 1'b0;
		rsp_d = '0;
		if (!inr_s1) begin
			rsp_d.status = ST_INVALID;
		end else if (op_s1 == OP_ALLOC) begin
			if (hit) begin
				rsp_d.status = ST_MAPPED;
				rsp_d.frame  = FRAME_W'(cur_frame);
			end else if (next_frame_q == FCW'(NUM_FRAMES_P)) begin
				rsp_d.status = ST_NO_FRAME;
			end else begin
				rsp_d.status = ST_OK;
				rsp_d.frame  = FRAME_W'(wr_frame);
				wr_en        = vld_s1;
			end
		end else begin
			if (!hit) begin
				rsp_d.status = ST_FAULT;
			end else begin
				rsp_d.status = ST_OK;
				rsp_d.paddr  = PHYS_W'(phys_full);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			next_frame_q  <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= vld_s1;
			if (wr_en) begin
				entry_valid_q[idx_s1] <= 1'b1;
				next_frame_q          <= next_frame_q + FCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

@@ tb/page_table_alloc_translate_top_tb.sv @@
// testbench for the page table allocate and translate block, directed and random requests
`timescale 1ns / 1ps

module page_table_alloc_translate_top_tb;
	import ptat_pkg::*;

	localparam int N_PAGES     = 16;
	localparam int N_FRAMES    = 8;
	localparam int PG_BYTES    = 256;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	logic               page_mapped [N_PAGES];
	logic [FRAME_W-1:0] page_frame  [N_PAGES];
	logic               frame_taken [N_FRAMES];

	rsp_t table_rsp_q[$];
	int   n_errors;
	int   n_sent;
	int   n_checked;
	int   n_status [5];
	int   cycle_count;
	bit   gapless;

	page_table_alloc_translate_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL");
			$finish;
		end
	end

	function automatic rsp_t predict_table_access(input req_t r);
		rsp_t                 o;
		int unsigned          pg;
		int unsigned          offs;
		bit                   found;
		o = '0;
		if (r.op == OP_ALLOC) begin
			pg = r.vpage;
			if (pg >= N_PAGES) begin
				o.status = ST_INVALID;
			end else if (page_mapped[pg]) begin
				o.status = ST_MAPPED;
				o.frame  = page_frame[pg];
			end else begin
				found = 1'b0;
				for (int f = 0; f < N_FRAMES; f++) begin
					if (!found && !frame_taken[f]) begin
						found          = 1'b1;
						frame_taken[f] = 1'b1;
						page_frame[pg] = FRAME_W'(f);
						page_mapped[pg] = 1'b1;
						o.status       = ST_OK;
						o.frame        = FRAME_W'(f);
					end
				end
				if (!found)
					o.status = ST_NO_FRAME;
			end
		end else begin
			pg   = r.vaddr / PG_BYTES;
			offs = r.vaddr % PG_BYTES;
			if (pg >= N_PAGES) begin
				o.status = ST_INVALID;
			end else if (!page_mapped[pg]) begin
				o.status = ST_FAULT;
			end else begin
				o.status = ST_OK;
				o.paddr  = PHYS_W'(page_frame[pg] * PG_BYTES + offs);
			end
		end
		return o;
	endfunction

	// result check, then prediction of the transfer taken at this edge
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (table_rsp_q.size() == 0) begin
				$error("result with nothing pending: status %0d frame %0d phys %0h",
					rsp.status, rsp.frame, rsp.paddr);
				n_errors++;
			end else begin
				want = table_rsp_q.pop_front();
				n_checked++;
				if (want.status < 5)
					n_status[want.status]++;
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					n_errors++;
				end
				if (rsp.frame !== want.frame) begin
					$error("frame: expected %0d, got %0d", want.frame, rsp.frame);
					n_errors++;
				end
				if (rsp.paddr !== want.paddr) begin
					$error("paddr: expected %0h, got %0h",
						want.paddr, rsp.paddr);
					n_errors++;
				end
			end
		end
		if (arst_n && start && !busy)
			table_rsp_q.push_back(predict_table_access(req));
	end

	function automatic req_t alloc_req(input logic [PAGE_W-1:0] pg);
		req_t r;
		r       = '0;
		r.op    = OP_ALLOC;
		r.vpage = pg;
		r.vaddr = VADDR_W'($urandom);
		return r;
	endfunction

	function automatic req_t xlate_req(input logic [VADDR_W-1:0] va);
		req_t r;
		r       = '0;
		r.op    = OP_XLATE;
		r.vpage = PAGE_W'($urandom);
		r.vaddr = va;
		return r;
	endfunction

	task automatic send_request(input req_t r);
		int gap;
		gap = gapless ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
		n_sent++;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (table_rsp_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_alloc_basic();
		send_request(alloc_req(5'd0));
		send_request(alloc_req(5'd0));
		send_request(alloc_req(5'd31));
		send_request(alloc_req(5'd16));
	endtask

	task automatic test_translate_basic();
		send_request(xlate_req(16'h00ff));
		send_request(xlate_req(16'h0f00));
		send_request(xlate_req(16'h1000));
		send_request(xlate_req(16'hffff));
	endtask

	task automatic test_random_mix(input int count);
		req_t r;
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0)
				gapless = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 2) == 0) begin
				if ($urandom_range(0, 3) != 0)
					r = alloc_req(PAGE_W'($urandom_range(0, N_PAGES - 1)));
				else
					r = alloc_req(PAGE_W'($urandom));
			end else begin
				if ($urandom_range(0, 3) != 0)
					r = xlate_req(VADDR_W'($urandom_range(0, N_PAGES * PG_BYTES - 1)));
				else
					r = xlate_req(VADDR_W'($urandom));
			end
			send_request(r);
		end
		gapless = 1'b0;
	endtask

	// map every page, so the frames run out
	task automatic test_frames_exhausted();
		for (int p = N_PAGES - 1; p >= 0; p--)
			send_request(alloc_req(PAGE_W'(p)));
		send_request(xlate_req(16'h0000));
	endtask

	initial begin
		arst_n      <= 1'b0;
		start       <= 1'b0;
		req         <= '0;
		n_errors    = 0;
		n_sent      = 0;
		n_checked   = 0;
		cycle_count = 0;
		gapless     = 1'b0;
		foreach (n_status[i]) n_status[i] = 0;
		foreach (page_mapped[i]) page_mapped[i] = 1'b0;
		foreach (page_frame[i]) page_frame[i] = '0;
		foreach (frame_taken[i]) frame_taken[i] = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_alloc_basic();
		test_translate_basic();
		drain_results();
		test_random_mix(1900);
		drain_results();
		test_frames_exhausted();
		drain_results();
		repeat (10) @(posedge clk);

		if (table_rsp_q.size() != 0) begin
			$error("%0d results never arrived", table_rsp_q.size());
			n_errors++;
		end
		$display("sent %0d requests, checked %0d results", n_sent, n_checked);
		$display("status seen: ok %0d, mapped %0d, invalid %0d, no frame %0d, fault %0d",
			n_status[ST_OK], n_status[ST_MAPPED], n_status[ST_INVALID],
			n_status[ST_NO_FRAME], n_status[ST_FAULT]);
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
